// ===== rtl/crfm_pkg.sv =====
// Shared types and constants for the circle raster fill mask block.
// Used by the channel interfaces and by the top level; depends on nothing.
package crfm_pkg;

	localparam int MAX_SIDE    = 128;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int ROW_W       = $clog2(MAX_SIDE);
	localparam int SIDE_W      = 8;
	localparam int COORD_W     = 7;
	localparam int WALK_LIMIT  = 4 * MAX_SIDE + 8;
	localparam int STEP_W      = $clog2(WALK_LIMIT + 1);
	localparam int MIN_SIDE    = 4;

	localparam logic [31:0] COLOUR_RESET = 32'hffff_ffff;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_SIDE = 2'd1,
		STATUS_OUTSIDE  = 2'd2
	} status_t;

endpackage

// ===== rtl/crfm_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on crfm_pkg for field widths.
interface crfm_req_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [crfm_pkg::SIDE_W-1:0]         side_length;
	logic [crfm_pkg::COORD_W-1:0]        pixel_x;
	logic [crfm_pkg::COORD_W-1:0]        pixel_y;

	modport source (output valid, output opcode, output side_length, output pixel_x,
		output pixel_y, input ready);
	modport sink (input valid, input opcode, input side_length, input pixel_x,
		input pixel_y, output ready);
endinterface

interface crfm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        pixel_on;
	logic [31:0] pixel_rgba;

	modport source (output valid, output status, output pixel_on, output pixel_rgba,
		input ready);
	modport sink (input valid, input status, input pixel_on, input pixel_rgba,
		output ready);
endinterface

// ===== rtl/circle_raster_fill_mask.sv =====
// Top level of the circle raster fill mask: sequencer, shared multiply-add unit,
// outline memory and per-row span memory.
// Depends on crfm_pkg and the channel interfaces in crfm_if.sv.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   opcode, side_length, pixel_x, pixel_y
//  rsp      out  valid/ready   status, pixel_on, pixel_rgba
//  cfg      in   cfg_wr_en     cfg_wr_data (draw colour)
//
// A draw sizes the canvas, clears the outline, walks the circle with eight point
// writes and one update per circle step, and scans each row pixel by pixel until it
// finds its span; the single outline read port and the shared multiplier set this.
// A read passes through S_RJ, S_R0, S_R1, S_R2 and S_R3 before it answers, a rejected
// item answers in the cycle after its transfer.
// After reset nothing is drawn.
// The block holds one item at a time and waits while a response is not taken.
module circle_raster_fill_mask (
	input  logic                clk,
	input  logic                arst_n,
	crfm_req_if.sink            req,
	crfm_rsp_if.source          rsp,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_CLR, S_WALK, S_STEP,
		S_SA, S_SB, S_SC, S_SD,
		S_RJ, S_R0, S_R1, S_R2, S_R3
	} state_t;

	localparam int AW = crfm_pkg::ADDR_W;
	localparam int CW = crfm_pkg::CNT_W;
	localparam int SW = crfm_pkg::SIDE_W;
	localparam int RW = crfm_pkg::ROW_W;

	state_t                     state_q;
	logic [31:0]                colour_q;
	logic [31:0]                drawn_colour_q;
	logic [SW-1:0]              cur_side_q;
	logic [SW-1:0]              side_q;
	logic [CW-1:0]              n_q;
	logic signed [9:0]          c_q, x_q, y_q;
	logic signed [11:0]         d_q;
	logic [crfm_pkg::STEP_W-1:0] steps_q;
	logic [2:0]                 k_q;
	logic [CW-1:0]              clr_q;
	logic [SW-1:0]              row_q, col_q;
	logic [CW-1:0]              base_q;
	logic [CW-1:0]              b_addr_q;
	logic [CW-1:0]              j_q;
	logic [crfm_pkg::COORD_W-1:0] px_q, py_q;
	logic                       o_j_q, o_m_q;
	logic                       rsp_valid_q;
	crfm_pkg::status_t          status_q;
	logic                       on_q;
	logic [31:0]                rgba_q;

	logic                       outline_mem [crfm_pkg::STORE_DEPTH];
	logic                       ol_rd_q;
	logic                       rok_q;
	logic [SW-1:0]              span_mem [crfm_pkg::MAX_SIDE];
	logic [SW-1:0]              span_rd_q;

	logic                       ol_we, ol_wd, rd_ok, span_we, ol_bit;
	logic [CW-1:0]              ol_wa, rd_addr;
	logic [SW-1:0]              span_wd;
	logic signed [9:0]          mul_a, mul_c, w_row, w_col;
	logic [SW-1:0]              mul_b;
	logic signed [19:0]         ma, mb, mc, prod;
	logic                       prod_in;
	logic                       hit, miss_end, row_end;
	logic signed [11:0]         gap, d_y;
	logic [SW-1:0]              half, rad;
	logic                       fire;
	logic                       span_on;

	assign fire   = req.valid && req.ready;
	assign ol_bit = ol_rd_q && rok_q;

	assign ma      = 20'(mul_a);
	assign mb      = 20'(mul_b);
	assign mc      = 20'(mul_c);
	assign prod    = ma * mb + mc;
	assign prod_in = (prod >= 0) && (prod < $signed(20'(n_q)));

	assign half = req.side_length >> 1;
	assign rad  = half[0] ? half - SW'(2) : half - SW'(1);

	assign d_y = d_q + 12'(y_q);
	assign gap = (d_y <<< 1) - 12'sd1;

	assign hit      = (state_q == S_SC || state_q == S_SD) && ol_bit;
	assign miss_end = (col_q == side_q - SW'(1)) && !ol_bit
		&& (state_q == S_SB || state_q == S_SD);
	assign row_end  = hit || miss_end;

	assign span_on = ({1'b0, px_q} >= span_rd_q)
		&& ((9'(px_q) + 9'(span_rd_q)) < 9'(cur_side_q));

	always_comb begin
		w_row = c_q + y_q;
		w_col = c_q + x_q;
		case (k_q)
			3'd0: begin w_row = c_q + y_q;          w_col = c_q + x_q;          end
			3'd1: begin w_row = c_q + y_q - 10'sd1; w_col = c_q + x_q - 10'sd1; end
			3'd2: begin w_row = c_q - y_q;          w_col = c_q + x_q;          end
			3'd3: begin w_row = c_q - y_q + 10'sd1; w_col = c_q + x_q - 10'sd1; end
			3'd4: begin w_row = c_q + y_q;          w_col = c_q - x_q;          end
			3'd5: begin w_row = c_q + y_q - 10'sd1; w_col = c_q - x_q + 10'sd1; end
			3'd6: begin w_row = c_q - y_q;          w_col = c_q - x_q;          end
			default: begin w_row = c_q - y_q + 10'sd1; w_col = c_q - x_q + 10'sd1; end
		endcase
	end

	always_comb begin
		mul_a   = w_row;
		mul_b   = side_q;
		mul_c   = w_col;
		ol_we   = 1'b0;
		ol_wd   = 1'b0;
		ol_wa   = clr_q;
		rd_addr = base_q + CW'(col_q);
		rd_ok   = 1'b1;
		span_we = row_end;
		span_wd = hit ? col_q : side_q;
		unique case (state_q)
			S_PREP: begin
				mul_a = 10'(side_q);
				mul_c = '0;
			end
			S_CLR: begin
				ol_we = 1'b1;
			end
			S_WALK: begin
				ol_we = prod_in;
				ol_wd = 1'b1;
				ol_wa = prod[CW-1:0];
			end
			S_SB: begin
				rd_addr = b_addr_q;
			end
			S_SC: begin
				rd_addr = b_addr_q - CW'(1);
				rd_ok   = (b_addr_q != '0);
			end
			S_RJ: begin
				mul_a = 10'(py_q);
				mul_b = cur_side_q;
				mul_c = 10'(px_q);
			end
			S_R0: begin
				rd_addr = j_q;
			end
			S_R1: begin
				rd_addr = j_q - CW'(1);
				rd_ok   = (j_q != '0);
			end
			S_R2: begin
				rd_addr = j_q + CW'(1);
				rd_ok   = ((j_q + CW'(1)) < n_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ol_we) begin
			outline_mem[ol_wa[AW-1:0]] <= ol_wd;
		end
		ol_rd_q <= outline_mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (span_we) begin
			span_mem[row_q[RW-1:0]] <= span_wd;
		end
		span_rd_q <= span_mem[py_q[RW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rok_q <= 1'b0;
		end else begin
			rok_q <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= crfm_pkg::COLOUR_RESET;
		end else if (cfg_wr_en) begin
			colour_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			drawn_colour_q <= crfm_pkg::COLOUR_RESET;
			cur_side_q     <= '0;
			n_q            <= '0;
			rsp_valid_q    <= 1'b0;
			status_q       <= crfm_pkg::STATUS_OK;
			on_q           <= 1'b0;
			rgba_q         <= '0;
			side_q         <= '0;
			c_q            <= '0;
			x_q            <= '0;
			y_q            <= '0;
			d_q            <= '0;
			steps_q        <= '0;
			k_q            <= '0;
			clr_q          <= '0;
			row_q          <= '0;
			col_q          <= '0;
			base_q         <= '0;
			b_addr_q       <= '0;
			j_q            <= '0;
			px_q           <= '0;
			py_q           <= '0;
			o_j_q          <= 1'b0;
			o_m_q          <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						on_q   <= 1'b0;
						rgba_q <= '0;
						if (req.opcode == crfm_pkg::OP_DRAW) begin
							if (req.side_length < SW'(crfm_pkg::MIN_SIDE)
								|| req.side_length > SW'(crfm_pkg::MAX_SIDE)) begin
								status_q    <= crfm_pkg::STATUS_BAD_SIDE;
								rsp_valid_q <= 1'b1;
							end else begin
								side_q  <= req.side_length;
								c_q     <= 10'(half);
								x_q     <= '0;
								y_q     <= 10'(rad);
								d_q     <= 12'sd3 - (12'(rad) <<< 1);
								state_q <= S_PREP;
							end
						end else if (cur_side_q == '0
							|| SW'(req.pixel_x) >= cur_side_q
							|| SW'(req.pixel_y) >= cur_side_q) begin
							status_q    <= crfm_pkg::STATUS_OUTSIDE;
							rsp_valid_q <= 1'b1;
						end else begin
							px_q    <= req.pixel_x;
							py_q    <= req.pixel_y;
							state_q <= S_RJ;
						end
					end
				end
				S_PREP: begin
					n_q     <= prod[CW-1:0];
					clr_q   <= '0;
					state_q <= S_CLR;
				end
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == n_q - CW'(1)) begin
						k_q     <= '0;
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					steps_q <= steps_q + crfm_pkg::STEP_W'(1);
					if (d_q < 0 && gap <= 0) begin
						x_q <= x_q + 10'sd1;
						d_q <= d_q + (12'(x_q) <<< 1) + 12'sd3;
					end else if (d_q > 0 && gap > 0) begin
						y_q <= y_q - 10'sd1;
						d_q <= d_q - (12'(y_q) <<< 1) + 12'sd1;
					end else begin
						x_q <= x_q + 10'sd1;
						y_q <= y_q - 10'sd1;
						d_q <= d_q + ((12'(x_q) - 12'(y_q) + 12'sd1) <<< 1);
					end
					if ((d_q > 0 && gap > 0) || !(d_q < 0 && gap <= 0)) begin
						if (y_q == 10'sd0
							|| steps_q + crfm_pkg::STEP_W'(1)
							>= crfm_pkg::STEP_W'(crfm_pkg::WALK_LIMIT)) begin
							row_q   <= '0;
							col_q   <= '0;
							base_q  <= '0;
							state_q <= S_SA;
						end else begin
							state_q <= S_WALK;
						end
					end else if (steps_q + crfm_pkg::STEP_W'(1)
						>= crfm_pkg::STEP_W'(crfm_pkg::WALK_LIMIT)) begin
						row_q   <= '0;
						col_q   <= '0;
						base_q  <= '0;
						state_q <= S_SA;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_SA: begin
					b_addr_q <= base_q + CW'(side_q) - CW'(1) - CW'(col_q);
					state_q  <= S_SB;
				end
				S_SB, S_SC, S_SD: begin
					if (row_end) begin
						col_q <= '0;
						if (row_q == side_q - SW'(1)) begin
							cur_side_q     <= side_q;
							drawn_colour_q <= colour_q;
							status_q       <= crfm_pkg::STATUS_OK;
							rsp_valid_q    <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							row_q   <= row_q + SW'(1);
							base_q  <= base_q + CW'(side_q);
							state_q <= S_SA;
						end
					end else if (state_q == S_SB) begin
						state_q <= ol_bit ? S_SC : S_SA;
						if (!ol_bit) begin
							col_q <= col_q + SW'(1);
						end
					end else if (state_q == S_SC) begin
						state_q <= S_SD;
					end else begin
						col_q   <= col_q + SW'(1);
						state_q <= S_SA;
					end
				end
				S_RJ: begin
					j_q     <= prod[CW-1:0];
					state_q <= S_R0;
				end
				S_R0: begin
					state_q <= S_R1;
				end
				S_R1: begin
					o_j_q   <= ol_bit;
					state_q <= S_R2;
				end
				S_R2: begin
					o_m_q   <= ol_bit;
					state_q <= S_R3;
				end
				S_R3: begin
					status_q    <= crfm_pkg::STATUS_OK;
					on_q        <= o_j_q || (o_m_q && ol_bit) || span_on;
					rgba_q      <= (o_j_q || (o_m_q && ol_bit) || span_on)
						? drawn_colour_q : '0;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.pixel_on   = on_q;
	assign rsp.pixel_rgba = rgba_q;

endmodule
